@@ rtl/amdf_pkg.sv @@
// Package for the addressed message deframer: parser states, message kinds,
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package amdf_pkg;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ADDR,
        ST_SUB,
        ST_LEN,
        ST_BODY,
        ST_SHOW
    } state_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_SYSTEM = 2'd0;
    localparam kind_t KIND_DEVICE = 2'd1;
    localparam kind_t KIND_PONG   = 2'd2;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_START_MARKER = 3'd0;
    localparam cfg_idx_t CFG_SYSTEM_ADDR  = 3'd1;
    localparam cfg_idx_t CFG_DEVICE_ADDR  = 3'd2;
    localparam cfg_idx_t CFG_SUB_MIN      = 3'd3;
    localparam cfg_idx_t CFG_SUB_MAX      = 3'd4;
    localparam cfg_idx_t CFG_PING_COMMAND = 3'd5;

    localparam int MAX_RESULTS = 16;

endpackage

@@ rtl/addressed_message_deframer_unit.sv @@
// Addressed message deframer: byte stream in, one request out per payload byte.
// Depends on amdf_pkg.
//
// Usage: received bytes enter on the s_ channel, one per request. The parser
// hunts for the start marker, checks the address and sub-address bytes against
// the configuration registers, takes the body length and writes the body
// (command byte, then payload) into a body memory with one write port and one
// registered read port. Frames with a bad address, bad sub-address, zero length
// or a length above MAX_BODY (or above 17) are dropped and hunting resumes.
// Throughput: while parsing, one byte is taken every cycle. After the final
// body byte, the first result appears on the m_ channel in the next cycle; each
// further result follows in the cycle after the previous one is taken, as the
// body memory read port streams the payload. A body of N bytes therefore
// gives max(N-1,1) results, and s_tready stays low until the last one is
// taken. A frame with no payload gives one result.
// When the receiver stalls, the current result holds and the read pointer
// waits. Reset returns the parser to hunting and loads the register defaults;
// the body memory is not cleared, since only entries of the current frame are
// shown. Configuration is written through cfg_we / cfg_index / cfg_data.
`timescale 1ns / 1ps

module addressed_message_deframer_unit #(
    parameter int MAX_BODY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [amdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    // byte input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [7:0] sub_address, [15:8] command,
                                                     // [23:16] payload_byte,
                                                     // [24] payload_valid, rest zero
    output logic [1:0]                    m_tuser,   // [1:0] msg_kind
    output logic                          m_tlast    // last_of_message
);

    localparam int AW      = $clog2(MAX_BODY);
    localparam int CW      = $clog2(MAX_BODY + 1);
    localparam int LEN_MAX = (MAX_BODY < amdf_pkg::MAX_RESULTS + 1) ?
                             MAX_BODY : amdf_pkg::MAX_RESULTS + 1;

    amdf_pkg::state_t state_reg, state_next;

    logic [7:0] start_marker_reg;
    logic [7:0] system_addr_reg;
    logic [7:0] device_addr_reg;
    logic [7:0] sub_min_reg;
    logic [7:0] sub_max_reg;
    logic [7:0] ping_command_reg;

    logic                  is_system_reg, is_system_next;
    logic [7:0]            sub_reg, sub_next;
    logic [7:0]            cmd_reg, cmd_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    amdf_pkg::kind_t       kind_reg, kind_next;

    logic [7:0]            body_mem [MAX_BODY];
    logic [7:0]            rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;

    logic                  in_acc;
    logic                  out_acc;
    logic [CW-1:0]         count_inc;
    logic [7:0]            cmd_src;
    logic                  pay_valid;
    logic                  last_res;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign count_inc = count_reg + CW'(1);
    assign cmd_src   = (count_reg == '0) ? s_tdata : cmd_reg;
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_en     = in_acc && (state_reg == amdf_pkg::ST_BODY);
    assign pay_valid = (len_reg != CW'(1));
    assign last_res  = !pay_valid || ((CW'(ptr_reg) + CW'(1)) == len_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= 8'd77;
            system_addr_reg  <= 8'd0;
            device_addr_reg  <= 8'd1;
            sub_min_reg      <= 8'd1;
            sub_max_reg      <= 8'd8;
            ping_command_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                amdf_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                amdf_pkg::CFG_SYSTEM_ADDR:  system_addr_reg  <= cfg_data;
                amdf_pkg::CFG_DEVICE_ADDR:  device_addr_reg  <= cfg_data;
                amdf_pkg::CFG_SUB_MIN:      sub_min_reg      <= cfg_data;
                amdf_pkg::CFG_SUB_MAX:      sub_max_reg      <= cfg_data;
                amdf_pkg::CFG_PING_COMMAND: ping_command_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // body memory, read data registered, write forwarded to a same-edge read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            body_mem[wr_addr] <= s_tdata;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rdata_reg <= s_tdata;
        end
        else
        begin
            rdata_reg <= body_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amdf_pkg::ST_HUNT;
            is_system_reg <= 1'b0;
            sub_reg       <= 8'd0;
            len_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmd_reg       <= 8'd0;
            kind_reg      <= amdf_pkg::KIND_SYSTEM;
        end
        else
        begin
            state_reg     <= state_next;
            is_system_reg <= is_system_next;
            sub_reg       <= sub_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            cmd_reg       <= cmd_next;
            kind_reg      <= kind_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        is_system_next = is_system_reg;
        sub_next       = sub_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmd_next       = cmd_reg;
        kind_next      = kind_reg;
        rd_addr        = AW'(1);
        s_tready       = 1'b1;
        m_tvalid       = 1'b0;

        unique case (state_reg)
            amdf_pkg::ST_HUNT:
            begin
                if (in_acc && (s_tdata == start_marker_reg))
                begin
                    state_next = amdf_pkg::ST_ADDR;
                end
            end
            amdf_pkg::ST_ADDR:
            begin
                if (in_acc)
                begin
                    if (s_tdata == system_addr_reg)
                    begin
                        is_system_next = 1'b1;
                        state_next     = amdf_pkg::ST_SUB;
                    end
                    else if (s_tdata == device_addr_reg)
                    begin
                        is_system_next = 1'b0;
                        state_next     = amdf_pkg::ST_SUB;
                    end
                    else
                    begin
                        state_next = amdf_pkg::ST_HUNT;
                    end
                end
            end
            amdf_pkg::ST_SUB:
            begin
                if (in_acc)
                begin
                    if ((s_tdata == 8'd0) ||
                        ((s_tdata >= sub_min_reg) && (s_tdata <= sub_max_reg)))
                    begin
                        sub_next   = s_tdata;
                        state_next = amdf_pkg::ST_LEN;
                    end
                    else
                    begin
                        state_next = amdf_pkg::ST_HUNT;
                    end
                end
            end
            amdf_pkg::ST_LEN:
            begin
                if (in_acc)
                begin
                    if ((s_tdata == 8'd0) || (s_tdata > 8'(LEN_MAX)))
                    begin
                        state_next = amdf_pkg::ST_HUNT;
                    end
                    else
                    begin
                        len_next   = s_tdata[CW-1:0];
                        count_next = '0;
                        state_next = amdf_pkg::ST_BODY;
                    end
                end
            end
            amdf_pkg::ST_BODY:
            begin
                if (in_acc)
                begin
                    count_next = count_inc;
                    cmd_next   = cmd_src;
                    if (count_inc == len_reg)
                    begin
                        if (!is_system_reg)
                        begin
                            kind_next = amdf_pkg::KIND_DEVICE;
                        end
                        else if (cmd_src == ping_command_reg)
                        begin
                            kind_next = amdf_pkg::KIND_PONG;
                        end
                        else
                        begin
                            kind_next = amdf_pkg::KIND_SYSTEM;
                        end
                        ptr_next   = AW'(1);
                        state_next = amdf_pkg::ST_SHOW;
                    end
                end
            end
            amdf_pkg::ST_SHOW:
            begin
                s_tready = 1'b0;
                m_tvalid = 1'b1;
                rd_addr  = ptr_reg;
                if (out_acc)
                begin
                    if (last_res)
                    begin
                        state_next = amdf_pkg::ST_HUNT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                        rd_addr  = ptr_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = amdf_pkg::ST_HUNT;
            end
        endcase
    end

    assign m_tdata = {7'd0, pay_valid, (pay_valid ? rdata_reg : 8'd0), cmd_reg, sub_reg};
    assign m_tuser = kind_reg;
    assign m_tlast = last_res;

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == amdf_pkg::ST_BODY && in_acc && count_inc == len_reg) |=> m_tvalid)
        else $error("final body byte did not start result output");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("output continued after last result");

    a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == amdf_pkg::ST_BODY || state_reg == amdf_pkg::ST_SHOW) |->
        (len_reg != '0 && len_reg <= CW'(LEN_MAX)))
        else $error("body length out of range");

    a_ptr_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && pay_valid) |-> (CW'(ptr_reg) < len_reg))
        else $error("read pointer beyond body");

endmodule

@@ tb/tb_top.sv @@
// Testbench for addressed_message_deframer_unit: byte driver, result monitor and a frame
// parser model that predicts every request on the m_ channel. Depends on amdf_pkg and the RTL.
// Directed frames first, then random frames and noise under several register settings.
`timescale 1ns / 1ps

module tb_top;

    localparam int       CLK_PERIOD    = 4;
    localparam int       BODY_DEPTH    = 16;
    localparam int       IDLE_PCT      = 8;
    localparam int       SETTLE_CYCLES = 10;
    localparam int       PHASE_BYTES   = 32;
    localparam amdf_pkg::cfg_idx_t CFG_UNUSED_6 = 3'd6;
    localparam amdf_pkg::cfg_idx_t CFG_UNUSED_7 = 3'd7;

    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'd77, 8'd0, 8'd0, 8'd1, 8'd128,
        8'd77, 8'd1, 8'd8, 8'd3, 8'd0, 8'd255, 8'd0,
        8'd77, 8'd77, 8'd77, 8'd0, 8'd9, 8'd77, 8'd1, 8'd1, 8'd0,
        8'd77, 8'd0, 8'd1, 8'd17
    };

    typedef struct {
        amdf_pkg::kind_t kind;
        logic [7:0]      sub_address;
        logic [7:0]      command;
        logic [7:0]      payload_byte;
        logic            payload_valid;
        logic            last_of_message;
    } message_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    amdf_pkg::cfg_idx_t cfg_index = amdf_pkg::CFG_START_MARKER;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [7:0] sub_address, [15:8] command, [23:16] payload_byte,
                                      // [24] payload_valid
    logic [1:0]  m_tuser;             // [1:0] msg_kind
    logic        m_tlast;             // last_of_message

    // parser model state and its copy of the registers
    amdf_pkg::state_t parse_state = amdf_pkg::ST_HUNT;
    logic        frame_is_system = 1'b0;
    logic [7:0]  frame_sub = 8'h00;
    logic [7:0]  frame_len = 8'h00;
    logic [7:0]  frame_count = 8'h00;
    logic [7:0]  frame_body [BODY_DEPTH];
    logic [7:0]  reg_start = 8'd77;
    logic [7:0]  reg_sys = 8'd0;
    logic [7:0]  reg_dev = 8'd1;
    logic [7:0]  reg_sub_min = 8'd1;
    logic [7:0]  reg_sub_max = 8'd8;
    logic [7:0]  reg_ping = 8'd128;

    message_t    pending_messages [$];
    logic [7:0]  rx_pending [$];
    message_t    head_msg;
    logic        steady = 1'b0;
    int          failures = 0;
    int          messages_checked = 0;
    int          pongs_checked = 0;
    int          bytes_queued = 0;
    int          settings_used = 0;

    addressed_message_deframer_unit #(
        .MAX_BODY (BODY_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic sub_ok(input logic [7:0] b);
        return (b == 8'd0) || (b >= reg_sub_min && b <= reg_sub_max);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        amdf_pkg::kind_t kind;
        message_t        msg;
        int              i;
        case (parse_state)
            amdf_pkg::ST_HUNT:
            begin
                if (b == reg_start)
                    parse_state = amdf_pkg::ST_ADDR;
            end
            amdf_pkg::ST_ADDR:
            begin
                if (b == reg_sys)
                begin
                    frame_is_system = 1'b1;
                    parse_state = amdf_pkg::ST_SUB;
                end
                else if (b == reg_dev)
                begin
                    frame_is_system = 1'b0;
                    parse_state = amdf_pkg::ST_SUB;
                end
                else
                    parse_state = amdf_pkg::ST_HUNT;
            end
            amdf_pkg::ST_SUB:
            begin
                if (sub_ok(b))
                begin
                    frame_sub = b;
                    parse_state = amdf_pkg::ST_LEN;
                end
                else
                    parse_state = amdf_pkg::ST_HUNT;
            end
            amdf_pkg::ST_LEN:
            begin
                if (b == 8'd0 || b > BODY_DEPTH || b > amdf_pkg::MAX_RESULTS + 1)
                    parse_state = amdf_pkg::ST_HUNT;
                else
                begin
                    frame_len = b;
                    frame_count = 8'd0;
                    parse_state = amdf_pkg::ST_BODY;
                end
            end
            amdf_pkg::ST_BODY:
            begin
                frame_body[frame_count] = b;
                frame_count = frame_count + 8'd1;
                if (frame_count >= frame_len)
                begin
                    if (!frame_is_system)
                        kind = amdf_pkg::KIND_DEVICE;
                    else if (frame_body[0] == reg_ping)
                        kind = amdf_pkg::KIND_PONG;
                    else
                        kind = amdf_pkg::KIND_SYSTEM;
                    msg.kind = kind;
                    msg.sub_address = frame_sub;
                    msg.command = frame_body[0];
                    if (frame_len == 8'd1)
                    begin
                        msg.payload_byte = 8'h00;
                        msg.payload_valid = 1'b0;
                        msg.last_of_message = 1'b1;
                        pending_messages.push_back(msg);
                    end
                    else
                    begin
                        for (i = 1; i < frame_len; i++)
                        begin
                            msg.payload_byte = frame_body[i];
                            msg.payload_valid = 1'b1;
                            msg.last_of_message = (i == frame_len - 1);
                            pending_messages.push_back(msg);
                        end
                    end
                    parse_state = amdf_pkg::ST_HUNT;
                end
            end
            default:
                parse_state = amdf_pkg::ST_HUNT;
        endcase
    endfunction

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            failures++;
        end
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (rx_pending.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_pending.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_messages.size() == 0)
                begin
                    $error("unexpected request: kind %0d, tdata %h", m_tuser, m_tdata);
                    failures++;
                end
                else
                begin
                    head_msg = pending_messages.pop_front();
                    check_field("msg_kind", head_msg.kind, m_tuser);
                    check_field("sub_address", head_msg.sub_address, m_tdata[7:0]);
                    check_field("command", head_msg.command, m_tdata[15:8]);
                    check_field("payload_byte", head_msg.payload_byte, m_tdata[23:16]);
                    check_field("payload_valid", head_msg.payload_valid, m_tdata[24]);
                    check_field("tdata_pad", 0, m_tdata[31:25]);
                    check_field("last_of_message", head_msg.last_of_message, m_tlast);
                    messages_checked++;
                    if (head_msg.kind == amdf_pkg::KIND_PONG)
                        pongs_checked++;
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input amdf_pkg::cfg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            amdf_pkg::CFG_START_MARKER: reg_start = val;
            amdf_pkg::CFG_SYSTEM_ADDR:  reg_sys = val;
            amdf_pkg::CFG_DEVICE_ADDR:  reg_dev = val;
            amdf_pkg::CFG_SUB_MIN:      reg_sub_min = val;
            amdf_pkg::CFG_SUB_MAX:      reg_sub_max = val;
            amdf_pkg::CFG_PING_COMMAND: reg_ping = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] good_sub();
        if (reg_sub_min <= reg_sub_max && $urandom_range(3) != 0)
            return 8'($urandom_range(reg_sub_max, reg_sub_min));
        return 8'd0;
    endfunction

    // mostly well-formed frames; noise never holds the start marker, so the parser
    // is back to hunting at the end of every call
    task automatic queue_random_frames(input int budget);
        int         stop_at;
        int         pick;
        int         len;
        int         tries;
        logic       found;
        logic [7:0] b;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    do
                        b = 8'($urandom);
                    while (b == reg_start);
                    queue_byte(b);
                end
            end
            else if (pick < 20)
            begin
                queue_byte(reg_start);
                pick = $urandom_range(2);
                if (pick == 0)
                begin
                    do
                        b = 8'($urandom);
                    while (b == reg_sys || b == reg_dev);
                    queue_byte(b);
                end
                else
                begin
                    queue_byte(reg_dev);
                    found = 1'b0;
                    if (pick == 1)
                    begin
                        for (tries = 0; tries < 32 && !found; tries++)
                        begin
                            b = 8'($urandom);
                            found = !sub_ok(b);
                        end
                    end
                    if (found)
                        queue_byte(b);
                    else
                    begin
                        queue_byte(good_sub());
                        queue_byte($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 17)));
                    end
                end
            end
            else
            begin
                queue_byte(reg_start);
                queue_byte($urandom_range(1) ? reg_sys : reg_dev);
                queue_byte(good_sub());
                len = ($urandom_range(7) == 0) ? BODY_DEPTH : $urandom_range(6, 1);
                queue_byte(8'(len));
                queue_byte(($urandom_range(3) == 0) ? reg_ping : 8'($urandom));
                repeat (len - 1)
                    queue_byte(8'($urandom));
            end
        end
    endtask

    // wait for every request to drain, then let a dropped frame finish
    task automatic drain_and_settle();
        while (rx_pending.size() != 0 || s_tvalid || pending_messages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] sys;
        logic [7:0] dev;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // register defaults after reset
        settings_used++;
        foreach (DIRECTED_BYTES[i])
            queue_byte(DIRECTED_BYTES[i]);
        queue_random_frames(PHASE_BYTES);
        drain_and_settle();

        // shared address, full sub-address range, no idling
        steady = 1'b1;
        settings_used++;
        write_reg(amdf_pkg::CFG_START_MARKER, 8'd255);
        write_reg(amdf_pkg::CFG_SYSTEM_ADDR, 8'd90);
        write_reg(amdf_pkg::CFG_DEVICE_ADDR, 8'd90);
        write_reg(amdf_pkg::CFG_SUB_MIN, 8'd0);
        write_reg(amdf_pkg::CFG_SUB_MAX, 8'd255);
        write_reg(amdf_pkg::CFG_PING_COMMAND, 8'd0);
        write_reg(CFG_UNUSED_6, 8'hFF);
        write_reg(CFG_UNUSED_7, 8'h00);
        queue_random_frames(PHASE_BYTES);
        drain_and_settle();
        steady = 1'b0;

        // empty sub-address range
        settings_used++;
        write_reg(amdf_pkg::CFG_START_MARKER, 8'd0);
        write_reg(amdf_pkg::CFG_SYSTEM_ADDR, 8'd255);
        write_reg(amdf_pkg::CFG_DEVICE_ADDR, 8'd0);
        write_reg(amdf_pkg::CFG_SUB_MIN, 8'd200);
        write_reg(amdf_pkg::CFG_SUB_MAX, 8'd100);
        write_reg(amdf_pkg::CFG_PING_COMMAND, 8'd255);
        queue_random_frames(PHASE_BYTES);
        drain_and_settle();

        settings_used++;
        lo = 8'($urandom);
        hi = 8'($urandom);
        sys = 8'($urandom);
        do
            dev = 8'($urandom);
        while (dev == sys);
        write_reg(amdf_pkg::CFG_START_MARKER, 8'($urandom));
        write_reg(amdf_pkg::CFG_SYSTEM_ADDR, sys);
        write_reg(amdf_pkg::CFG_DEVICE_ADDR, dev);
        write_reg(amdf_pkg::CFG_SUB_MIN, (lo < hi) ? lo : hi);
        write_reg(amdf_pkg::CFG_SUB_MAX, (lo < hi) ? hi : lo);
        write_reg(amdf_pkg::CFG_PING_COMMAND, 8'($urandom));
        queue_random_frames(PHASE_BYTES);
        drain_and_settle();

        $display("Sent %0d bytes under %0d register settings", bytes_queued, settings_used);
        $display("Checked %0d messages, %0d of them pong requests",
                 messages_checked, pongs_checked);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
